// ===== hdl/udc_pkg.sv =====
// Shared types, widths and divisor table for the UART baud divisor calculator.
// No dependencies; imported by uart_baud_divisor_calc and udc_eval.
`default_nettype none
package udc_pkg;

    localparam int unsigned FIELD_W   = 27;
    localparam int unsigned NUM_DIV   = 9;
    localparam int unsigned PROD_W    = FIELD_W + 8;
    localparam int unsigned DUTY_QW   = 10;
    localparam int unsigned SIDE2_W   = 14;
    localparam logic [FIELD_W-1:0] CLOCK_RESET = 27'd60000000;
    localparam logic [7:0] FAIL_COUNT = 8'd255;

    typedef struct packed {
        logic               fail;
        logic [3:0]         k;
        logic [7:0]         n;
        logic [7:0]         count;
        logic [FIELD_W-1:0] baud;
        logic [FIELD_W-1:0] clkv;
        logic [PROD_W-1:0]  prod;
        logic [FIELD_W-1:0] p;
        logic [FIELD_W-1:0] diff;
        logic               mod;
    } eval_t;

    function automatic logic div_half_clk(input logic [3:0] k);
        logic r;
        case (k)
            4'd0:    r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic div_dbl_speed(input logic [3:0] k);
        logic r;
        case (k)
            4'd0, 4'd1, 4'd3, 4'd5, 4'd7: r = 1'b1;
            default:                      r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] div_prescale(input logic [3:0] k);
        logic [1:0] r;
        case (k)
            4'd3, 4'd4: r = 2'd1;
            4'd5, 4'd6: r = 2'd2;
            4'd7, 4'd8: r = 2'd3;
            default:    r = 2'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/uart_baud_divisor_calc.sv =====
// Top level: UART baud divisor calculator, two division cell chains around udc_eval.
// Depends on udc_pkg, udc_div_cell and udc_eval.
//
// Channel  | Signals                                   | Handshake
// request  | start, busy, baud_rate                    | taken when start & !busy
// result   | result_valid, ok, rate_count, ...duty     | one-cycle strobe, no stall
// config   | cfg_valid, cfg_ready, cfg_data            | written when valid & ready
//
// One request per cycle; busy is always low. The pipeline is made of
// 27 cells of the clock/baud divider, 4 evaluation stages, 10 cells of the
// duty divider and one output register. The divider cell chains set most of its depth.
// Reset clears all valid flags and loads the clock register with 60 MHz.
// Results cannot be stalled; each transaction leaves the output register in order of arrival.
`default_nettype none
module uart_baud_divisor_calc (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [udc_pkg::FIELD_W-1:0] baud_rate,
    output logic                             result_valid,
    output logic                             ok,
    output logic [7:0]                       rate_count,
    output logic                             half_clock_select,
    output logic                             double_speed_select,
    output logic [1:0]                       prescale_select,
    output logic                             modulation_enable,
    output logic [7:0]                       modulation_duty,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [udc_pkg::FIELD_W-1:0] cfg_data
);
    import udc_pkg::*;

    localparam int unsigned NC1 = FIELD_W;

    logic [FIELD_W-1:0] clk_hz_reg;

    // chain 1: ratio = clock / baud, clock travels as sideband
    logic               c1_v    [0:NC1];
    logic [FIELD_W-1:0] c1_rem  [0:NC1];
    logic [FIELD_W-1:0] c1_num  [0:NC1];
    logic [FIELD_W-1:0] c1_den  [0:NC1];
    logic [FIELD_W-1:0] c1_side [0:NC1];

    // chain 2: twice-duty = P*512 / clock
    logic               c2_v    [0:DUTY_QW];
    logic [FIELD_W-1:0] c2_rem  [0:DUTY_QW];
    logic [DUTY_QW-1:0] c2_num  [0:DUTY_QW];
    logic [FIELD_W-1:0] c2_den  [0:DUTY_QW];
    logic [SIDE2_W-1:0] c2_side [0:DUTY_QW];

    logic       ev_valid;
    eval_t      ev;

    logic       fin_fail, fin_mod;
    logic [7:0] fin_count;
    logic [3:0] fin_k;
    logic [DUTY_QW:0] q_inc;

    logic       valid_reg;
    logic       ok_reg, ok_next;
    logic [7:0] count_reg, count_next;
    logic       half_reg, half_next;
    logic       dbl_reg, dbl_next;
    logic [1:0] pre_reg, pre_next;
    logic       men_reg, men_next;
    logic [7:0] duty_reg, duty_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg <= CLOCK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            clk_hz_reg <= cfg_data;
        end
    end

    assign c1_v[0]    = start && !busy;
    assign c1_rem[0]  = '0;
    assign c1_num[0]  = clk_hz_reg;
    assign c1_den[0]  = baud_rate;
    assign c1_side[0] = clk_hz_reg;

    for (genvar i = 0; i < NC1; i++)
    begin : g_c1
        udc_div_cell #(.W(FIELD_W), .QW(FIELD_W), .SW(FIELD_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c1_v[i]),
            .in_rem    (c1_rem[i]),
            .in_num    (c1_num[i]),
            .in_den    (c1_den[i]),
            .in_side   (c1_side[i]),
            .out_valid (c1_v[i+1]),
            .out_rem   (c1_rem[i+1]),
            .out_num   (c1_num[i+1]),
            .out_den   (c1_den[i+1]),
            .out_side  (c1_side[i+1])
        );
    end

    udc_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c1_v[NC1]),
        .ratio     (c1_num[NC1]),
        .baud      (c1_den[NC1]),
        .clkv      (c1_side[NC1]),
        .out_valid (ev_valid),
        .out_eval  (ev)
    );

    // P <= clock, so P/2 < clock starts a valid partial remainder
    assign c2_v[0]    = ev_valid;
    assign c2_rem[0]  = {1'b0, ev.p[FIELD_W-1:1]};
    assign c2_num[0]  = {ev.p[0], {(DUTY_QW-1){1'b0}}};
    assign c2_den[0]  = ev.clkv;
    assign c2_side[0] = {ev.fail, ev.count, ev.k, ev.mod};

    for (genvar j = 0; j < DUTY_QW; j++)
    begin : g_c2
        udc_div_cell #(.W(FIELD_W), .QW(DUTY_QW), .SW(SIDE2_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c2_v[j]),
            .in_rem    (c2_rem[j]),
            .in_num    (c2_num[j]),
            .in_den    (c2_den[j]),
            .in_side   (c2_side[j]),
            .out_valid (c2_v[j+1]),
            .out_rem   (c2_rem[j+1]),
            .out_num   (c2_num[j+1]),
            .out_den   (c2_den[j+1]),
            .out_side  (c2_side[j+1])
        );
    end

    assign {fin_fail, fin_count, fin_k, fin_mod} = c2_side[DUTY_QW];
    assign q_inc = {1'b0, c2_num[DUTY_QW]} + 11'd1;

    // final formatting; impossible rates give the reset-value result
    always_comb
    begin
        ok_next    = !fin_fail;
        count_next = fin_count;
        half_next  = div_half_clk(fin_k);
        dbl_next   = div_dbl_speed(fin_k);
        pre_next   = div_prescale(fin_k);
        men_next   = fin_mod;
        duty_next  = fin_mod ? q_inc[8:1] : 8'd0;
        if (fin_fail)
        begin
            count_next = FAIL_COUNT;
            half_next  = 1'b0;
            dbl_next   = 1'b0;
            pre_next   = 2'd0;
            men_next   = 1'b0;
            duty_next  = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= c2_v[DUTY_QW];
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg    <= ok_next;
        count_reg <= count_next;
        half_reg  <= half_next;
        dbl_reg   <= dbl_next;
        pre_reg   <= pre_next;
        men_reg   <= men_next;
        duty_reg  <= duty_next;
    end

    assign result_valid        = valid_reg;
    assign ok                  = ok_reg;
    assign rate_count          = count_reg;
    assign half_clock_select   = half_reg;
    assign double_speed_select = dbl_reg;
    assign prescale_select     = pre_reg;
    assign modulation_enable   = men_reg;
    assign modulation_duty     = duty_reg;

    // a transaction taken now yields a result after the fixed pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##42 result_valid)
        else $error("result strobe missing");

    a_fail_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !ok) |-> (rate_count == FAIL_COUNT && !modulation_enable))
        else $error("failed result not in reset form");

    a_duty_off: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !modulation_enable) |-> (modulation_duty == 8'd0))
        else $error("duty set without modulation");
endmodule
`default_nettype wire

// ===== hdl/udc_div_cell.sv =====
// One restoring-division cell: one quotient bit per cell, registered.
// Depends on nothing; chained by uart_baud_divisor_calc.
`default_nettype none
module udc_div_cell #(
    parameter int unsigned W  = 27,
    parameter int unsigned QW = 27,
    parameter int unsigned SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [W-1:0]  in_rem,
    input  wire logic [QW-1:0] in_num,
    input  wire logic [W-1:0]  in_den,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [W-1:0]       out_rem,
    output logic [QW-1:0]      out_num,
    output logic [W-1:0]       out_den,
    output logic [SW-1:0]      out_side
);
    logic [W:0]    trial;
    logic          fits;
    logic [W-1:0]  rem_next;
    logic [QW-1:0] num_next;
    logic          valid_reg;
    logic [W-1:0]  rem_reg;
    logic [QW-1:0] num_reg;
    logic [W-1:0]  den_reg;
    logic [SW-1:0] side_reg;

    // partial remainder stays below the divisor, so bit W is the borrow
    assign trial    = {in_rem, in_num[QW-1]} - {1'b0, in_den};
    assign fits     = ~trial[W];
    assign rem_next = fits ? trial[W-1:0] : {in_rem[W-2:0], in_num[QW-1]};
    assign num_next = {in_num[QW-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        den_reg  <= in_den;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;
endmodule
`default_nettype wire

// ===== hdl/udc_eval.sv =====
// Divisor selection, count, exact product and 1% error test; four stages.
// Depends on udc_pkg.
`default_nettype none
module udc_eval (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [udc_pkg::FIELD_W-1:0] ratio,
    input  wire logic [udc_pkg::FIELD_W-1:0] baud,
    input  wire logic [udc_pkg::FIELD_W-1:0] clkv,
    output logic                             out_valid,
    output udc_pkg::eval_t                   out_eval
);
    import udc_pkg::*;

    eval_t      s1_next, s2_next, s3_next, s4_next;
    eval_t      s1_reg, s2_reg, s3_reg, s4_reg;
    logic [3:0] v_reg;
    logic       found;
    logic [4:0] sh1, sh3;
    logic       half_lsb;

    // stage 1: first divisor with ratio < D*256, D = 8 << k
    always_comb
    begin
        s1_next = '0;
        found   = 1'b0;
        for (int i = NUM_DIV - 1; i >= 0; i--)
        begin
            if ((ratio >> (11 + i)) == '0)
            begin
                s1_next.k = 4'(i);
                found     = 1'b1;
            end
        end
        sh1          = {1'b0, s1_next.k} + 5'd3;
        s1_next.n    = 8'(ratio >> sh1);
        half_lsb     = ratio[sh1 - 5'd1];
        s1_next.count = half_lsb ? s1_next.n : s1_next.n - 8'd1;
        s1_next.fail = (baud == '0) || !found || (s1_next.n == 8'd0);
        s1_next.baud = baud;
        s1_next.clkv = clkv;
    end

    // stage 2: baud * n
    always_comb
    begin
        s2_next      = s1_reg;
        s2_next.prod = PROD_W'(s1_reg.baud) * PROD_W'(s1_reg.n);
    end

    // stage 3: P = baud*n*D, never above clock when a divisor was found
    always_comb
    begin
        s3_next      = s2_reg;
        sh3          = {1'b0, s2_reg.k} + 5'd3;
        s3_next.p    = FIELD_W'(s2_reg.prod << sh3);
        s3_next.diff = s2_reg.clkv - s3_next.p;
    end

    // stage 4: error above 1% selects modulation and a count of n-1
    always_comb
    begin
        s4_next       = s3_reg;
        s4_next.mod   = (34'(s3_reg.diff) * 34'd100) > 34'(s3_reg.p);
        s4_next.count = s4_next.mod ? s3_reg.n - 8'd1 : s3_reg.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        s3_reg <= s3_next;
        s4_reg <= s4_next;
    end

    assign out_valid = v_reg[3];
    assign out_eval  = s4_reg;
endmodule
`default_nettype wire

// ===== tb/sv/tb_uart_baud_divisor_calc.sv =====
// Testbench for uart_baud_divisor_calc: directed and random baud requests under
// several peripheral clock settings, checked against an in-bench divider predictor.
// Depends on udc_pkg and the RTL of uart_baud_divisor_calc.
`timescale 1ns / 1ps
module tb_uart_baud_divisor_calc;
    import udc_pkg::*;

    localparam int LATENCY    = 42;
    localparam int WDOG_LIMIT = 2000;

    // One predicted result of the divider.
    typedef struct {
        logic       ok;
        logic [7:0] rate_count;
        logic       half_clk;
        logic       dbl_speed;
        logic [1:0] prescale;
        logic       mod_en;
        logic [7:0] duty;
    } divsetting_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [FIELD_W-1:0]  baud_rate;
    logic                result_valid;
    logic                ok;
    logic [7:0]          rate_count;
    logic                half_clock_select;
    logic                double_speed_select;
    logic [1:0]          prescale_select;
    logic                modulation_enable;
    logic [7:0]          modulation_duty;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [FIELD_W-1:0]  cfg_data;

    divsetting_t         pending_settings[$];
    logic [FIELD_W-1:0]  clock_hz;
    int                  fail_count;
    int                  idle_cycles;
    int                  send_idle_pct;

    uart_baud_divisor_calc u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .baud_rate          (baud_rate),
        .result_valid       (result_valid),
        .ok                 (ok),
        .rate_count         (rate_count),
        .half_clock_select  (half_clock_select),
        .double_speed_select(double_speed_select),
        .prescale_select    (prescale_select),
        .modulation_enable  (modulation_enable),
        .modulation_duty    (modulation_duty),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Divider settings for one baud rate at the current clock.
    function automatic divsetting_t calc_divider(input logic [FIELD_W-1:0] baud);
        divsetting_t s;
        int unsigned divs[NUM_DIV];
        bit          hc[NUM_DIV];
        bit          ds[NUM_DIV];
        bit [1:0]    ps[NUM_DIV];
        longint unsigned ratio, d, n, half_q, cnt, p, diff, c64, twice;
        int          k;
        divs = '{8, 16, 32, 64, 128, 256, 512, 1024, 2048};
        hc   = '{1, 0, 0, 0, 0, 0, 0, 0, 0};
        ds   = '{1, 1, 0, 1, 0, 1, 0, 1, 0};
        ps   = '{0, 0, 0, 1, 1, 2, 2, 3, 3};
        s = '{ok: 1'b0, rate_count: 8'd255, half_clk: 1'b0, dbl_speed: 1'b0,
              prescale: 2'd0, mod_en: 1'b0, duty: 8'd0};
        if (baud == 0)
            return s;
        c64 = clock_hz;
        ratio = c64 / baud;
        k = -1;
        for (int i = NUM_DIV - 1; i >= 0; i--)
            if (ratio < divs[i] * 256)
                k = i;
        if (k < 0)
            return s;
        d = divs[k];
        n = ratio / d;
        if (n == 0)
            return s;
        half_q = ratio / (d / 2);
        cnt = half_q[0] ? half_q / 2 : half_q / 2 - 1;
        s.ok = 1'b1;
        s.half_clk = hc[k];
        s.dbl_speed = ds[k];
        s.prescale = ps[k];
        p = longint'(baud) * d * n;
        diff = (c64 >= p) ? c64 - p : p - c64;
        if (diff * 100 <= p)
        begin
            s.rate_count = cnt[7:0];
        end
        else
        begin
            twice = (p * 512) / c64;
            s.rate_count = 8'(n - 1);
            s.mod_en = 1'b1;
            s.duty = 8'((twice + 1) >> 1);
        end
        return s;
    endfunction

    // Result checker: every strobe is matched to the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            divsetting_t e;
            if (pending_settings.size() == 0)
            begin
                $display("%0t: unexpected result ok=%0b count=%0d", $time, ok, rate_count);
                fail_count++;
            end
            else
            begin
                e = pending_settings.pop_front();
                if ({ok, rate_count, half_clock_select, double_speed_select,
                     prescale_select, modulation_enable, modulation_duty} !==
                    {e.ok, e.rate_count, e.half_clk, e.dbl_speed,
                     e.prescale, e.mod_en, e.duty})
                begin
                    $display("%0t: mismatch expected ok=%0b cnt=%0d hc=%0b ds=%0b ps=%0d me=%0b m=%0d",
                             $time, e.ok, e.rate_count, e.half_clk, e.dbl_speed,
                             e.prescale, e.mod_en, e.duty);
                    $display("%0t:          actual ok=%0b cnt=%0d hc=%0b ds=%0b ps=%0d me=%0b m=%0d",
                             $time, ok, rate_count, half_clock_select, double_speed_select,
                             prescale_select, modulation_enable, modulation_duty);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: cycles with no accepted transaction on any channel.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Send one baud request; start stays high when the next request follows at once.
    task automatic send_baud(input logic [FIELD_W-1:0] baud);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        baud_rate <= baud;
        do @(posedge clk); while (busy);
        pending_settings.push_back(calc_divider(baud));
    endtask

    // Drop start and let the pipeline drain completely.
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        wait (pending_settings.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Clock register write, only with the pipeline idle.
    task automatic write_clock(input logic [FIELD_W-1:0] hz);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= hz;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        clock_hz = hz;
        @(posedge clk);
    endtask

    function automatic logic [FIELD_W-1:0] rand_baud;
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0:       return FIELD_W'($urandom);
            1:       return FIELD_W'($urandom_range(300));
            2:       return FIELD_W'(clock_hz / $urandom_range(1, 4096));
            3:       return FIELD_W'(clock_hz / $urandom_range(1, 600000));
            default: return FIELD_W'(clock_hz / $urandom_range(8, 2048 * 256));
        endcase
    endfunction

    task automatic test_reset_clock;
        // Reset value 60 MHz: common rates, edges and zero baud.
        logic [FIELD_W-1:0] bauds[13];
        bauds = '{27'd0, 27'd1, 27'd110, 27'd9600, 27'd115200, 27'd7500000,
                  27'd7500001, 27'd3750000, 27'd114, 27'd115, 27'h7FFFFFF,
                  27'd120000000, 27'd31250};
        foreach (bauds[i])
            send_baud(bauds[i]);
    endtask

    task automatic test_clock_extremes;
        // Minimum and maximum clock, plus a zero clock.
        write_clock(27'd1);
        send_baud(27'd1);
        send_baud(27'h7FFFFFF);
        write_clock(27'd120000000);
        send_baud(27'd1);
        send_baud(27'd15000000);
        send_baud(27'd1000000);
        send_baud(27'd120000000);
        write_clock(27'h7FFFFFF);
        send_baud(27'd57600);
        write_clock(27'd0);
        send_baud(27'd9600);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
            begin
                case ($urandom_range(3))
                    0: write_clock(FIELD_W'($urandom_range(1, 120000000)));
                    1: write_clock(FIELD_W'($urandom));
                    2: write_clock(27'd48000000);
                    default: write_clock(FIELD_W'($urandom_range(1000, 40000000)));
                endcase
            end
            send_baud(rand_baud());
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        baud_rate   = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        clock_hz    = CLOCK_RESET;
        fail_count  = 0;
        idle_cycles = 0;
        send_idle_pct = 25;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_clock();
        test_clock_extremes();
        write_clock(CLOCK_RESET);
        test_random(180);
        // pause until every pending result is back
        drain();
        send_idle_pct = 75;
        test_random(180);
        send_idle_pct = 0;
        test_random(180);

        start <= 1'b0;
        @(posedge clk);
        wait (pending_settings.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/udc_pkg.sv
hdl/udc_div_cell.sv
hdl/udc_eval.sv
hdl/uart_baud_divisor_calc.sv
tb/sv/tb_uart_baud_divisor_calc.sv
